// File: sv/rbc_pkg.sv
`default_nettype none
package rbc_pkg;

  localparam int unsigned BLK_W           = 12;
  localparam int unsigned BLK_MAX         = 4096;
  localparam int unsigned TOT_W           = 13;
  localparam int unsigned RUN_W           = 7;
  localparam int unsigned RUNMIN_W        = 10;
  localparam int unsigned SLOT_PW         = 8;
  localparam int unsigned SID_W           = 8;
  localparam int unsigned STAMP_W         = 32;
  localparam int unsigned PCT_W           = 7;
  localparam int unsigned PCT_FULL        = 100;
  localparam int unsigned PCT_EMERG       = 25;
  localparam int unsigned DEF_CACHE_SLOTS = 64;
  localparam int unsigned DEF_MAX_STREAMS = 8;
  localparam logic [TOT_W-1:0] TOTAL_RST  = 13'd4096;
  localparam logic [RUN_W-1:0] MINRUN_RST = 7'd4;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_SET    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_type_e;

  typedef enum logic {
    CFG_TOTAL_BLOCKS = 1'b0,
    CFG_MIN_RUN      = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    req_type_e          req_type;
    logic [SID_W-1:0]   stream_id;
    logic [BLK_W-1:0]   start_block;
    logic [BLK_W-1:0]   read_block;
    logic [BLK_W-1:0]   readahead_blocks;
    logic [BLK_W-1:0]   block_number;
    logic               demand;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic               hit;
    logic [SLOT_PW-1:0] hit_slot;
    logic               fetch_valid;
    logic [BLK_W-1:0]   fetch_block;
    logic [SLOT_PW-1:0] fetch_slot;
  } res_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_CLEAR, OP_EXEC, OP_LOOKUP, OP_LOOKCHK, OP_COMMIT, OP_MARK,
    OP_HALF_RD, OP_HALF_WR, OP_MARK_WR, OP_DEMAND, OP_DEMCHK, OP_VICT_RD,
    OP_VICT_CHK, OP_AVAIL_INIT, OP_AVAIL_RD, OP_AVAIL_CHK, OP_DIV_START,
    OP_DIV_WAIT, OP_AVAIL_NEXT, OP_PICK, OP_PICK_CHK, OP_EVICT, OP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   take;
    logic   emit;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_tick;
    logic pend_vld;
    logic lk_in_range;
    logic cached;
    logic mark_same;
    logic cnt_full;
    logic cnt_last;
    logic slot_free;
    logic no_streams;
    logic avail_stop;
    logic ra_zero;
    logic div_done;
    logic k_last;
    logic pick_fetch;
    logic out_free;
  } st_t;

endpackage
`default_nettype wire

// File: sv/rbc_div.sv
`default_nettype none
module rbc_div #(
  parameter int unsigned NW = 15,
  parameter int unsigned DW = 12
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  output logic               done_o,
  output logic [NW-1:0]      quot_o
);
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_q;
  logic [DW-1:0] rem_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [DW:0]   sh;
  logic          ge;

  // One quotient bit per cycle, restoring form.
  assign sh = {rem_q, q_q[NW-1]};
  assign ge = sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? DW'(sh - {1'b0, den_q}) : sh[DW-1:0];
      q_q   <= {q_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
endmodule
`default_nettype wire

// File: sv/rbc_datapath.sv
`default_nettype none
module rbc_datapath #(
  parameter int unsigned CACHE_SLOTS = 64,
  parameter int unsigned MAX_STREAMS = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rbc_pkg::cmd_t                 cmd_i,
  output rbc_pkg::st_t                       st_o,
  input  wire rbc_pkg::req_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rbc_pkg::res_t                      out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire rbc_pkg::cfg_reg_e             cfg_idx_i,
  input  wire logic [rbc_pkg::TOT_W-1:0]     cfg_wdata_i
);
  import rbc_pkg::*;

  localparam int unsigned SIW  = $clog2(CACHE_SLOTS);
  localparam int unsigned SMW  = $clog2(CACHE_SLOTS + 1);
  localparam int unsigned KW   = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_STREAMS + 1);
  localparam int unsigned NW   = $clog2(PCT_FULL * CACHE_SLOTS + 1);

  // Configuration and bookkeeping.
  logic [TOT_W-1:0]       total_q, tot;
  logic [RUN_W-1:0]       minrun_q;
  logic [CACHE_SLOTS-1:0] slot_vld_q, stamp_set_q;
  logic [STAMP_W-1:0]     use_cnt_q;
  logic [SIW-1:0]         last_q, mslot_q;
  logic [CNTW-1:0]        scnt_q;
  logic                   dem_vld_q, pend_vld_q, out_vld_q;
  logic [BLK_W-1:0]       dem_blk_q, pend_blk_q, run_ptr_q, clr_q, blk_q;
  logic [SIW-1:0]         pend_slot_q;
  logic [RUNMIN_W-1:0]    run_len_q, run_min_q;

  // Memories.
  logic [BLK_W-1:0]   slotblk_mem [CACHE_SLOTS];
  logic [STAMP_W-1:0] stamp_mem   [CACHE_SLOTS];
  logic [SMW-1:0]     bmap_mem    [BLK_MAX];
  logic [BLK_W-1:0]   slotblk_rd_q;
  logic [STAMP_W-1:0] stamp_rd_q;
  logic [SMW-1:0]     bmap_rd_q;

  // Stream table.
  logic [SID_W-1:0] desc_q  [MAX_STREAMS];
  logic [BLK_W-1:0] start_q [MAX_STREAMS];
  logic [BLK_W-1:0] rdp_q   [MAX_STREAMS];
  logic [BLK_W-1:0] ra_q    [MAX_STREAMS];

  // Scan state.
  req_t               req_q;
  res_t               res_q, out_q;
  logic [SIW-1:0]     cnt_q, best_q, victim_q;
  logic               best_vld_q;
  logic [STAMP_W-1:0] best_stamp_q;
  logic [KW-1:0]      k_q;
  logic [SMW-1:0]     n_q;
  logic               e_found_q, nf_found_q;
  logic [PCT_W-1:0]   e_least_q, nf_least_q;
  logic [BLK_W-1:0]   e_blk_q, nf_blk_q;
  logic [RUNMIN_W-1:0] e_ra4_q;

  dp_op_e op;
  assign op = cmd_i.op;

  assign tot = (total_q > TOT_W'(BLK_MAX)) ? TOT_W'(BLK_MAX) : total_q;

  logic [BLK_W-1:0] rd_k, ra_k;
  logic [TOT_W-1:0] pos;
  logic             cached, cnt_last;
  assign rd_k     = rdp_q[k_q];
  assign ra_k     = ra_q[k_q];
  assign pos      = {1'b0, rd_k} + TOT_W'(n_q);
  assign cached   = bmap_rd_q < SMW'(CACHE_SLOTS);
  assign cnt_last = cnt_q == SIW'(CACHE_SLOTS - 1);

  // A slot is protected if any stream starts at, reads at, or reads ahead into its block.
  logic               prot, better;
  logic [STAMP_W-1:0] vstamp;
  always_comb begin
    prot = 1'b0;
    for (int k = 0; k < MAX_STREAMS; k++) begin
      if (CNTW'(k) < scnt_q) begin
        if (start_q[k] == slotblk_rd_q || rdp_q[k] == slotblk_rd_q) prot = 1'b1;
        if (ra_q[k] != '0 && slotblk_rd_q >= rdp_q[k] &&
            {1'b0, slotblk_rd_q} < ({1'b0, rdp_q[k]} + {1'b0, ra_q[k]})) prot = 1'b1;
      end
    end
  end
  assign vstamp = stamp_set_q[cnt_q] ? stamp_rd_q : '0;
  assign better = !prot && (!best_vld_q || vstamp < best_stamp_q);

  // Stream lookup by descriptor.
  logic          found, full;
  logic [KW-1:0] fidx, widx, lidx;
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int k = 0; k < MAX_STREAMS; k++) begin
      if (!found && CNTW'(k) < scnt_q && desc_q[k] == req_q.stream_id) begin
        found = 1'b1;
        fidx  = KW'(k);
      end
    end
  end
  assign full = scnt_q == CNTW'(MAX_STREAMS);
  assign widx = found ? fidx : scnt_q[KW-1:0];
  assign lidx = KW'(scnt_q - CNTW'(1));

  // Next-block choice: continue the run, else emergency, demand, lowest percent.
  logic [RUNMIN_W-1:0] rl, p_len, p_min, e_min;
  logic [TOT_W-1:0]    nxt;
  logic                p_go, pick_fetch;
  logic [BLK_W-1:0]    p_blk;
  always_comb begin
    rl    = (run_len_q >= run_min_q) ? '0 : run_len_q;
    nxt   = {1'b0, run_ptr_q} + TOT_W'(1);
    e_min = (e_ra4_q > RUNMIN_W'(minrun_q)) ? e_ra4_q : RUNMIN_W'(minrun_q);
    p_min = run_min_q;
    p_go  = 1'b1;
    p_blk = '0;
    if (rl != '0 && nxt < tot) begin
      p_len = rl + RUNMIN_W'(1);
      p_blk = nxt[BLK_W-1:0];
    end else begin
      p_len = RUNMIN_W'(1);
      if (e_found_q) begin
        p_min = e_min;
        p_blk = e_blk_q;
      end else begin
        p_min = RUNMIN_W'(minrun_q);
        if (dem_vld_q) begin
          p_blk = dem_blk_q;
        end else if (nf_found_q) begin
          p_blk = nf_blk_q;
        end else begin
          p_go  = 1'b0;
          p_len = '0;
        end
      end
    end
    pick_fetch = p_go && ({1'b0, p_blk} < tot);
  end

  logic [BLK_W-1:0] dem_clamp;
  assign dem_clamp = ({1'b0, dem_blk_q} >= tot) ? '0 : dem_blk_q;

  // Percentage unit.
  logic          div_done;
  logic [NW-1:0] pct;
  rbc_div #(.NW(NW), .DW(BLK_W)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(op == OP_DIV_START),
    .num_i  (NW'(n_q) * NW'(PCT_FULL)),
    .den_i  (ra_k),
    .done_o (div_done),
    .quot_o (pct)
  );
  logic pos_in, upd_e, upd_n;
  assign pos_in = pos < tot;
  assign upd_e  = op == OP_DIV_WAIT && div_done && pos_in &&
                  pct < NW'(PCT_EMERG) && pct < NW'(e_least_q);
  assign upd_n  = op == OP_DIV_WAIT && div_done && pos_in && pct < NW'(nf_least_q);

  // Memory port selection.
  logic             bmap_we, bmap_re, sb_we, sb_re, st_we, st_re;
  logic [BLK_W-1:0] bmap_wa, bmap_ra, sb_wd;
  logic [SMW-1:0]   bmap_wd;
  logic [SIW-1:0]   sb_wa, sb_ra, st_wa;
  logic [STAMP_W-1:0] st_wd;
  always_comb begin
    bmap_we = 1'b0; bmap_wa = clr_q; bmap_wd = SMW'(CACHE_SLOTS);
    bmap_re = 1'b0; bmap_ra = req_q.block_number;
    sb_we = 1'b0; sb_wa = pend_slot_q; sb_wd = pend_blk_q;
    sb_re = 1'b0; sb_ra = cnt_q;
    st_we = 1'b0; st_wa = cnt_q; st_wd = stamp_rd_q >> 1;
    st_re = 1'b0;
    case (op)
      OP_CLEAR: bmap_we = 1'b1;
      OP_COMMIT: begin
        bmap_we = 1'b1;
        bmap_wa = pend_blk_q;
        bmap_wd = SMW'(pend_slot_q);
        sb_we   = 1'b1;
      end
      OP_EVICT: begin
        bmap_we = slot_vld_q[victim_q];
        bmap_wa = slotblk_rd_q;
      end
      OP_LOOKUP:   bmap_re = 1'b1;
      OP_DEMAND: begin
        bmap_re = 1'b1;
        bmap_ra = dem_clamp;
      end
      OP_AVAIL_RD: begin
        bmap_re = 1'b1;
        bmap_ra = pos[BLK_W-1:0];
      end
      OP_PICK: begin
        bmap_re = 1'b1;
        bmap_ra = p_blk;
      end
      OP_PICK_CHK: begin
        sb_re = 1'b1;
        sb_ra = victim_q;
      end
      OP_VICT_RD: begin
        sb_re = 1'b1;
        st_re = 1'b1;
      end
      OP_HALF_RD: st_re = 1'b1;
      OP_HALF_WR: st_we = stamp_set_q[cnt_q];
      OP_MARK_WR: begin
        st_we = 1'b1;
        st_wa = mslot_q;
        st_wd = use_cnt_q + STAMP_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bmap_we) bmap_mem[bmap_wa] <= bmap_wd;
    if (bmap_re) bmap_rd_q <= bmap_mem[bmap_ra];
    if (sb_we) slotblk_mem[sb_wa] <= sb_wd;
    if (sb_re) slotblk_rd_q <= slotblk_mem[sb_ra];
    if (st_we) stamp_mem[st_wa] <= st_wd;
    if (st_re) stamp_rd_q <= stamp_mem[cnt_q];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TOTAL_RST;
      minrun_q    <= MINRUN_RST;
      slot_vld_q  <= '0;
      stamp_set_q <= '0;
      use_cnt_q   <= '0;
      last_q      <= '0;
      scnt_q      <= '0;
      dem_vld_q   <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      clr_q       <= '0;
      run_ptr_q   <= '0;
      run_len_q   <= '0;
      run_min_q   <= RUNMIN_W'(1);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TOTAL_BLOCKS: total_q  <= cfg_wdata_i;
          CFG_MIN_RUN:      minrun_q <= cfg_wdata_i[RUN_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.emit) out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
      case (op)
        OP_CLEAR: clr_q <= clr_q + BLK_W'(1);
        OP_EXEC: begin
          if (req_q.req_type == REQ_SET && !found && !full) scnt_q <= scnt_q + CNTW'(1);
          if (req_q.req_type == REQ_REMOVE && found) scnt_q <= scnt_q - CNTW'(1);
        end
        OP_LOOKCHK: begin
          if (!cached && req_q.demand) dem_vld_q <= 1'b1;
        end
        OP_COMMIT: begin
          slot_vld_q[pend_slot_q] <= 1'b1;
          pend_vld_q <= 1'b0;
        end
        OP_HALF_WR: begin
          if (cnt_last) use_cnt_q <= use_cnt_q >> 1;
        end
        OP_MARK_WR: begin
          use_cnt_q <= use_cnt_q + STAMP_W'(1);
          stamp_set_q[mslot_q] <= 1'b1;
          last_q <= mslot_q;
        end
        OP_DEMCHK: begin
          if (dem_vld_q && cached) dem_vld_q <= 1'b0;
        end
        OP_PICK: begin
          run_len_q <= p_len;
          run_min_q <= p_min;
          run_ptr_q <= p_go ? p_blk : '0;
        end
        OP_EVICT: begin
          slot_vld_q[victim_q] <= 1'b0;
          pend_vld_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q <= in_data_i;
      res_q <= '0;
    end
    if (cmd_i.emit) out_q <= res_q;
    if (upd_e) begin
      e_found_q <= 1'b1;
      e_least_q <= pct[PCT_W-1:0];
      e_blk_q   <= pos[BLK_W-1:0];
      e_ra4_q   <= ra_k[BLK_W-1:2];
    end
    if (upd_n) begin
      nf_found_q <= 1'b1;
      nf_least_q <= pct[PCT_W-1:0];
      nf_blk_q   <= pos[BLK_W-1:0];
    end
    case (op)
      OP_EXEC: begin
        if (req_q.req_type == REQ_SET) begin
          res_q.accepted <= found || !full;
          if (found || !full) begin
            desc_q[widx]  <= req_q.stream_id;
            start_q[widx] <= req_q.start_block;
            rdp_q[widx]   <= req_q.read_block;
            ra_q[widx]    <= req_q.readahead_blocks;
          end
        end else begin
          res_q.accepted <= 1'b1;
          if (found) begin
            desc_q[fidx]  <= desc_q[lidx];
            start_q[fidx] <= start_q[lidx];
            rdp_q[fidx]   <= rdp_q[lidx];
            ra_q[fidx]    <= ra_q[lidx];
          end
        end
      end
      OP_LOOKCHK: begin
        if (cached) begin
          res_q.hit      <= 1'b1;
          res_q.hit_slot <= SLOT_PW'(bmap_rd_q);
          mslot_q        <= bmap_rd_q[SIW-1:0];
        end else if (req_q.demand) begin
          dem_blk_q <= req_q.block_number;
        end
      end
      OP_COMMIT: mslot_q <= pend_slot_q;
      OP_MARK: cnt_q <= '0;
      OP_HALF_WR: cnt_q <= cnt_q + SIW'(1);
      OP_DEMAND: begin
        if (dem_vld_q) dem_blk_q <= dem_clamp;
      end
      OP_DEMCHK: begin
        cnt_q      <= '0;
        best_vld_q <= 1'b0;
      end
      OP_VICT_RD: begin
        if (!slot_vld_q[cnt_q]) victim_q <= cnt_q;
      end
      OP_VICT_CHK: begin
        if (better) begin
          best_vld_q   <= 1'b1;
          best_q       <= cnt_q;
          best_stamp_q <= vstamp;
        end
        if (cnt_last) begin
          if (better) victim_q <= cnt_q;
          else if (best_vld_q) victim_q <= best_q;
          else victim_q <= '0;
        end else begin
          cnt_q <= cnt_q + SIW'(1);
        end
      end
      OP_AVAIL_INIT: begin
        k_q        <= '0;
        n_q        <= '0;
        e_found_q  <= 1'b0;
        nf_found_q <= 1'b0;
        e_least_q  <= PCT_W'(PCT_FULL);
        nf_least_q <= PCT_W'(PCT_FULL);
      end
      OP_AVAIL_CHK: begin
        if (cached) n_q <= n_q + SMW'(1);
      end
      OP_AVAIL_NEXT: begin
        n_q <= '0;
        if (!st_o.k_last) k_q <= k_q + KW'(1);
      end
      OP_PICK: blk_q <= p_blk;
      OP_EVICT: begin
        pend_blk_q        <= blk_q;
        pend_slot_q       <= victim_q;
        res_q.fetch_valid <= 1'b1;
        res_q.fetch_block <= blk_q;
        res_q.fetch_slot  <= SLOT_PW'(victim_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    st_o.clear_done  = clr_q == BLK_W'(BLK_MAX - 1);
    st_o.is_tick     = req_q.req_type == REQ_TICK;
    st_o.pend_vld    = pend_vld_q;
    st_o.lk_in_range = {1'b0, req_q.block_number} < tot;
    st_o.cached      = cached;
    st_o.mark_same   = mslot_q == last_q;
    st_o.cnt_full    = &use_cnt_q;
    st_o.cnt_last    = cnt_last;
    st_o.slot_free   = !slot_vld_q[cnt_q];
    st_o.no_streams  = scnt_q == '0;
    st_o.avail_stop  = n_q == SMW'(CACHE_SLOTS) || pos >= tot;
    st_o.ra_zero     = ra_k == '0;
    st_o.div_done    = div_done;
    st_o.k_last      = (CNTW'(k_q) + CNTW'(1)) == scnt_q;
    st_o.pick_fetch  = pick_fetch;
    st_o.out_free    = !out_vld_q || out_ready_i;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
endmodule
`default_nettype wire

// File: sv/rbc_ctrl.sv
`default_nettype none
module rbc_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire rbc_pkg::req_type_e in_req_type_i,
  output logic                    in_ready_o,
  input  wire rbc_pkg::st_t       st_i,
  output rbc_pkg::cmd_t           cmd_o
);
  import rbc_pkg::*;

  typedef enum logic [23:0] {
    ST_CLEAR      = 24'h000001,
    ST_IDLE       = 24'h000002,
    ST_EXEC       = 24'h000004,
    ST_LOOKUP     = 24'h000008,
    ST_LOOKCHK    = 24'h000010,
    ST_COMMIT     = 24'h000020,
    ST_MARK       = 24'h000040,
    ST_HALF_RD    = 24'h000080,
    ST_HALF_WR    = 24'h000100,
    ST_MARK_WR    = 24'h000200,
    ST_DEMAND     = 24'h000400,
    ST_DEMCHK     = 24'h000800,
    ST_VICT_RD    = 24'h001000,
    ST_VICT_CHK   = 24'h002000,
    ST_AVAIL_INIT = 24'h004000,
    ST_AVAIL_RD   = 24'h008000,
    ST_AVAIL_CHK  = 24'h010000,
    ST_DIV_START  = 24'h020000,
    ST_DIV_WAIT   = 24'h040000,
    ST_AVAIL_NEXT = 24'h080000,
    ST_PICK       = 24'h100000,
    ST_PICK_CHK   = 24'h200000,
    ST_EVICT      = 24'h400000,
    ST_RESULT     = 24'h800000
  } state_e;

  state_e state_q, state_d, ret_st, after_avail;
  logic   in_fire;

  assign in_ready_o  = state_q == ST_IDLE;
  assign in_fire     = in_valid_i && in_ready_o;
  assign ret_st      = st_i.is_tick ? ST_DEMAND : ST_RESULT;
  assign after_avail = st_i.ra_zero ? ST_AVAIL_NEXT : ST_DIV_START;

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_IDLE;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (st_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_req_type_i)
            REQ_TICK:   state_d = st_i.pend_vld ? ST_COMMIT : ST_DEMAND;
            REQ_LOOKUP: state_d = ST_LOOKUP;
            default:    state_d = ST_EXEC;
          endcase
        end
      end
      ST_EXEC: begin
        cmd_o.op = OP_EXEC;
        state_d = ST_RESULT;
      end
      ST_LOOKUP: begin
        cmd_o.op = OP_LOOKUP;
        state_d = st_i.lk_in_range ? ST_LOOKCHK : ST_RESULT;
      end
      ST_LOOKCHK: begin
        cmd_o.op = OP_LOOKCHK;
        state_d = st_i.cached ? ST_MARK : ST_RESULT;
      end
      ST_COMMIT: begin
        cmd_o.op = OP_COMMIT;
        state_d = ST_MARK;
      end
      ST_MARK: begin
        cmd_o.op = OP_MARK;
        if (st_i.mark_same) state_d = ret_st;
        else if (st_i.cnt_full) state_d = ST_HALF_RD;
        else state_d = ST_MARK_WR;
      end
      ST_HALF_RD: begin
        cmd_o.op = OP_HALF_RD;
        state_d = ST_HALF_WR;
      end
      ST_HALF_WR: begin
        cmd_o.op = OP_HALF_WR;
        state_d = st_i.cnt_last ? ST_MARK_WR : ST_HALF_RD;
      end
      ST_MARK_WR: begin
        cmd_o.op = OP_MARK_WR;
        state_d = ret_st;
      end
      ST_DEMAND: begin
        cmd_o.op = OP_DEMAND;
        state_d = ST_DEMCHK;
      end
      ST_DEMCHK: begin
        cmd_o.op = OP_DEMCHK;
        state_d = ST_VICT_RD;
      end
      ST_VICT_RD: begin
        cmd_o.op = OP_VICT_RD;
        state_d = st_i.slot_free ? ST_AVAIL_INIT : ST_VICT_CHK;
      end
      ST_VICT_CHK: begin
        cmd_o.op = OP_VICT_CHK;
        state_d = st_i.cnt_last ? ST_AVAIL_INIT : ST_VICT_RD;
      end
      ST_AVAIL_INIT: begin
        cmd_o.op = OP_AVAIL_INIT;
        state_d = st_i.no_streams ? ST_PICK : ST_AVAIL_RD;
      end
      ST_AVAIL_RD: begin
        cmd_o.op = OP_AVAIL_RD;
        state_d = st_i.avail_stop ? after_avail : ST_AVAIL_CHK;
      end
      ST_AVAIL_CHK: begin
        cmd_o.op = OP_AVAIL_CHK;
        state_d = st_i.cached ? ST_AVAIL_RD : after_avail;
      end
      ST_DIV_START: begin
        cmd_o.op = OP_DIV_START;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        cmd_o.op = OP_DIV_WAIT;
        if (st_i.div_done) state_d = ST_AVAIL_NEXT;
      end
      ST_AVAIL_NEXT: begin
        cmd_o.op = OP_AVAIL_NEXT;
        state_d = st_i.k_last ? ST_PICK : ST_AVAIL_RD;
      end
      ST_PICK: begin
        cmd_o.op = OP_PICK;
        state_d = st_i.pick_fetch ? ST_PICK_CHK : ST_RESULT;
      end
      ST_PICK_CHK: begin
        cmd_o.op = OP_PICK_CHK;
        state_d = st_i.cached ? ST_RESULT : ST_EVICT;
      end
      ST_EVICT: begin
        cmd_o.op = OP_EVICT;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        cmd_o.op = OP_RESULT;
        if (st_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign cmd_o.take = in_fire;
  assign cmd_o.emit = state_q == ST_RESULT && st_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// File: sv/readahead_block_cache_controller_unit.sv
`default_nettype none
// Block-cache controller with LRU replacement and stream read-ahead. After reset the
// block-to-slot map is cleared in a pass over all 4096 entries, during which no request beat
// is taken (configuration writes still are). Each request yields exactly one result beat.
// A lookup takes longer when the use counter saturates and all stamps are halved. A tick
// is bounded by its slot and map scans: a victim search over the slots, then for each
// stream a run of block-map reads and a percentage division, plus commit and issue; all of
// it runs through single-port memories read one entry per cycle. One request is worked on
// at a time; a finished result waits in the output register while the next request is taken.
module readahead_block_cache_controller_unit #(
  parameter int unsigned CACHE_SLOTS = rbc_pkg::DEF_CACHE_SLOTS,
  parameter int unsigned MAX_STREAMS = rbc_pkg::DEF_MAX_STREAMS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire rbc_pkg::req_t             in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output rbc_pkg::res_t                  out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire rbc_pkg::cfg_reg_e         cfg_idx_i,
  input  wire logic [rbc_pkg::TOT_W-1:0] cfg_wdata_i
);
  import rbc_pkg::*;

  cmd_t cmd;
  st_t  st;

  rbc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_req_type_i(in_data_i.req_type),
    .in_ready_o   (in_ready_o),
    .st_i         (st),
    .cmd_o        (cmd)
  );

  rbc_datapath #(
    .CACHE_SLOTS(CACHE_SLOTS),
    .MAX_STREAMS(MAX_STREAMS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_o       (st),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );
endmodule
`default_nettype wire
